// ===== hdl/efp_pkg.sv =====
package efp_pkg;

    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned RELIABILITY_W = 3;
    localparam int unsigned PAYLOAD_LEN_W = 14;
    localparam int unsigned BIT_LEN_W     = 16;
    localparam int unsigned INDEX24_W     = 24;
    localparam int unsigned SPLIT_CNT_W   = 32;
    localparam int unsigned SPLIT_ID_W    = 16;

    // Largest frame payload in bytes: a 16-bit bit length rounded up.
    localparam logic [PAYLOAD_LEN_W-1:0] MAX_PAYLOAD_LEN = 14'd8192;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_TRUNC   = 2'd2
    } kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_datagram;
    } word_t;

    typedef struct packed {
        kind_t                    result_kind;
        logic [RELIABILITY_W-1:0] reliability;
        logic                     split_flag;
        logic [PAYLOAD_LEN_W-1:0] payload_length;
        logic [INDEX24_W-1:0]     message_index;
        logic [INDEX24_W-1:0]     order_index;
        logic [BYTE_W-1:0]        order_channel;
        logic [SPLIT_CNT_W-1:0]   split_count;
        logic [SPLIT_ID_W-1:0]    split_id;
        logic [SPLIT_CNT_W-1:0]   split_index;
        logic [BYTE_W-1:0]        payload_byte;
        logic                     frame_end;
    } result_t;

endpackage

// ===== hdl/efp_interfaces.sv =====
interface efp_byte_if;
    import efp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_datagram;

    modport source (output valid, output data_byte, output end_of_datagram, input ready);
    modport sink   (input valid, input data_byte, input end_of_datagram, output ready);
endinterface

interface efp_result_if;
    import efp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               result_kind;
    logic [RELIABILITY_W-1:0] reliability;
    logic                     split_flag;
    logic [PAYLOAD_LEN_W-1:0] payload_length;
    logic [INDEX24_W-1:0]     message_index;
    logic [INDEX24_W-1:0]     order_index;
    logic [BYTE_W-1:0]        order_channel;
    logic [SPLIT_CNT_W-1:0]   split_count;
    logic [SPLIT_ID_W-1:0]    split_id;
    logic [SPLIT_CNT_W-1:0]   split_index;
    logic [BYTE_W-1:0]        payload_byte;
    logic                     frame_end;

    modport source (
        output valid, output result_kind, output reliability, output split_flag,
        output payload_length, output message_index, output order_index,
        output order_channel, output split_count, output split_id, output split_index,
        output payload_byte, output frame_end, input ready
    );
    modport sink (
        input valid, input result_kind, input reliability, input split_flag,
        input payload_length, input message_index, input order_index,
        input order_channel, input split_count, input split_id, input split_index,
        input payload_byte, input frame_end, output ready
    );
endinterface

// ===== hdl/efp_in_stage.sv =====
module efp_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    efp_byte_if.sink       bytes,
    input  logic           take,
    output logic           word_valid,
    output efp_pkg::word_t word
);
    import efp_pkg::*;

    logic  valid_reg;
    word_t word_reg;

    // Refill in the same cycle the parser drains the held word.
    assign bytes.ready = !valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            word_reg  <= '0;
        end
        else if (bytes.valid && bytes.ready)
        begin
            valid_reg                <= 1'b1;
            word_reg.data_byte       <= bytes.data_byte;
            word_reg.end_of_datagram <= bytes.end_of_datagram;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;
endmodule

// ===== hdl/efp_parser.sv =====
module efp_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           word_valid,
    input  efp_pkg::word_t word,
    output logic           take,
    efp_result_if.source   results
);
    import efp_pkg::*;

    typedef enum logic [3:0] {
        PH_FLAGS   = 4'd0,
        PH_LEN_HI  = 4'd1,
        PH_LEN_LO  = 4'd2,
        PH_MSG     = 4'd3,
        PH_ORD     = 4'd4,
        PH_CHAN    = 4'd5,
        PH_SCNT    = 4'd6,
        PH_SID     = 4'd7,
        PH_SIDX    = 4'd8,
        PH_DONE    = 4'd9,
        PH_PAYLOAD = 4'd10
    } phase_t;

    localparam logic [RELIABILITY_W-1:0] REL_UNRELIABLE_SEQ = 3'd1;
    localparam logic [RELIABILITY_W-1:0] REL_RELIABLE       = 3'd2;
    localparam logic [RELIABILITY_W-1:0] REL_RELIABLE_ORD   = 3'd3;
    localparam logic [RELIABILITY_W-1:0] REL_RELIABLE_SEQ   = 3'd4;
    localparam logic [RELIABILITY_W-1:0] REL_RELIABLE_ACK   = 3'd6;
    localparam logic [RELIABILITY_W-1:0] REL_RELIABLE_O_ACK = 3'd7;

    function automatic logic has_msg_index(logic [RELIABILITY_W-1:0] rel);
        return rel == REL_RELIABLE || rel == REL_RELIABLE_ORD || rel == REL_RELIABLE_SEQ
            || rel == REL_RELIABLE_ACK || rel == REL_RELIABLE_O_ACK;
    endfunction

    function automatic logic has_order(logic [RELIABILITY_W-1:0] rel);
        return rel == REL_UNRELIABLE_SEQ || rel == REL_RELIABLE_ORD
            || rel == REL_RELIABLE_SEQ || rel == REL_RELIABLE_O_ACK;
    endfunction

    // Next header field that is present after ph, or PH_DONE.
    function automatic phase_t after_field(phase_t ph, logic [RELIABILITY_W-1:0] rel,
                                           logic spl);
        phase_t nxt;
        priority if (ph == PH_LEN_LO && has_msg_index(rel))
            nxt = PH_MSG;
        else if ((ph == PH_LEN_LO || ph == PH_MSG) && has_order(rel))
            nxt = PH_ORD;
        else if (ph == PH_ORD)
            nxt = PH_CHAN;
        else if ((ph == PH_LEN_LO || ph == PH_MSG || ph == PH_CHAN) && spl)
            nxt = PH_SCNT;
        else if (ph == PH_SCNT)
            nxt = PH_SID;
        else if (ph == PH_SID)
            nxt = PH_SIDX;
        else
            nxt = PH_DONE;
        return nxt;
    endfunction

    phase_t                   phase_reg, phase_next;
    logic [1:0]               fc_reg, fc_next;
    logic [RELIABILITY_W-1:0] rel_reg, rel_next;
    logic                     split_reg, split_next;
    logic [BIT_LEN_W-1:0]     bitlen_reg, bitlen_next;
    logic [PAYLOAD_LEN_W-1:0] remain_reg, remain_next;
    logic [INDEX24_W-1:0]     msg_reg, msg_next;
    logic [INDEX24_W-1:0]     ord_reg, ord_next;
    logic [BYTE_W-1:0]        chan_reg, chan_next;
    logic [SPLIT_CNT_W-1:0]   scnt_reg, scnt_next;
    logic [SPLIT_ID_W-1:0]    sid_reg, sid_next;
    logic [SPLIT_CNT_W-1:0]   sidx_reg, sidx_next;
    logic                     out_valid_reg, out_valid_next;
    result_t                  res_reg, res_next;

    logic                     emit;
    logic [BYTE_W-1:0]        b;
    logic [BIT_LEN_W:0]       len_sum;
    logic [PAYLOAD_LEN_W-1:0] len;

    assign b    = word.data_byte;
    assign take = word_valid && (!out_valid_reg || results.ready);

    assign len_sum = {1'b0, bitlen_next} + 17'd7;
    assign len     = len_sum[BIT_LEN_W:3];

    always_comb
    begin
        phase_next  = phase_reg;
        fc_next     = fc_reg;
        rel_next    = rel_reg;
        split_next  = split_reg;
        bitlen_next = bitlen_reg;
        remain_next = remain_reg;
        msg_next    = msg_reg;
        ord_next    = ord_reg;
        chan_next   = chan_reg;
        scnt_next   = scnt_reg;
        sid_next    = sid_reg;
        sidx_next   = sidx_reg;
        res_next    = '0;
        emit        = 1'b0;

        unique case (phase_reg)
            PH_LEN_HI:
            begin
                bitlen_next = {b, 8'h00};
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                bitlen_next = {bitlen_reg[15:8], b};
                phase_next  = after_field(PH_LEN_LO, rel_reg, split_reg);
            end
            PH_MSG:
            begin
                // little-endian: byte fc lands at bit 8*fc
                msg_next = msg_reg | (24'(b) << {fc_reg, 3'b000});
                fc_next  = fc_reg + 2'd1;
                if (fc_reg == 2'd2)
                begin
                    fc_next    = 2'd0;
                    phase_next = after_field(PH_MSG, rel_reg, split_reg);
                end
            end
            PH_ORD:
            begin
                ord_next = ord_reg | (24'(b) << {fc_reg, 3'b000});
                fc_next  = fc_reg + 2'd1;
                if (fc_reg == 2'd2)
                begin
                    fc_next    = 2'd0;
                    phase_next = after_field(PH_ORD, rel_reg, split_reg);
                end
            end
            PH_CHAN:
            begin
                chan_next  = b;
                phase_next = after_field(PH_CHAN, rel_reg, split_reg);
            end
            PH_SCNT:
            begin
                scnt_next = {scnt_reg[23:0], b};
                fc_next   = fc_reg + 2'd1;
                if (fc_reg == 2'd3)
                begin
                    fc_next    = 2'd0;
                    phase_next = after_field(PH_SCNT, rel_reg, split_reg);
                end
            end
            PH_SID:
            begin
                sid_next = {sid_reg[7:0], b};
                fc_next  = fc_reg + 2'd1;
                if (fc_reg == 2'd1)
                begin
                    fc_next    = 2'd0;
                    phase_next = after_field(PH_SID, rel_reg, split_reg);
                end
            end
            PH_SIDX:
            begin
                sidx_next = {sidx_reg[23:0], b};
                fc_next   = fc_reg + 2'd1;
                if (fc_reg == 2'd3)
                begin
                    fc_next    = 2'd0;
                    phase_next = after_field(PH_SIDX, rel_reg, split_reg);
                end
            end
            PH_PAYLOAD:
            begin
                remain_next          = remain_reg - 14'd1;
                res_next.result_kind = KIND_PAYLOAD;
                res_next.payload_byte = b;
                emit                 = 1'b1;
                if (remain_next == '0)
                begin
                    res_next.frame_end = 1'b1;
                    phase_next         = PH_FLAGS;
                end
            end
            default:
            begin
                // flags byte; unused phase codes behave the same
                rel_next    = b[7:5];
                split_next  = b[4];
                bitlen_next = '0;
                msg_next    = '0;
                ord_next    = '0;
                chan_next   = '0;
                scnt_next   = '0;
                sid_next    = '0;
                sidx_next   = '0;
                fc_next     = 2'd0;
                phase_next  = PH_LEN_HI;
            end
        endcase

        if (phase_next == PH_DONE)
        begin
            remain_next             = len;
            res_next.result_kind    = KIND_HEADER;
            res_next.reliability    = rel_next;
            res_next.split_flag     = split_next;
            res_next.payload_length = len;
            res_next.message_index  = msg_next;
            res_next.order_index    = ord_next;
            res_next.order_channel  = chan_next;
            res_next.split_count    = scnt_next;
            res_next.split_id       = sid_next;
            res_next.split_index    = sidx_next;
            res_next.frame_end      = (len == '0);
            phase_next              = (len == '0) ? PH_FLAGS : PH_PAYLOAD;
            emit                    = 1'b1;
        end

        // datagram ended with a frame still open
        if (word.end_of_datagram && phase_next != PH_FLAGS)
        begin
            res_next             = '0;
            res_next.result_kind = KIND_TRUNC;
            phase_next           = PH_FLAGS;
            fc_next              = 2'd0;
            remain_next          = '0;
            emit                 = 1'b1;
        end

        if (take && emit)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FLAGS;
            fc_reg        <= 2'd0;
            rel_reg       <= '0;
            split_reg     <= 1'b0;
            bitlen_reg    <= '0;
            remain_reg    <= '0;
            msg_reg       <= '0;
            ord_reg       <= '0;
            chan_reg      <= '0;
            scnt_reg      <= '0;
            sid_reg       <= '0;
            sidx_reg      <= '0;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                phase_reg  <= phase_next;
                fc_reg     <= fc_next;
                rel_reg    <= rel_next;
                split_reg  <= split_next;
                bitlen_reg <= bitlen_next;
                remain_reg <= remain_next;
                msg_reg    <= msg_next;
                ord_reg    <= ord_next;
                chan_reg   <= chan_next;
                scnt_reg   <= scnt_next;
                sid_reg    <= sid_next;
                sidx_reg   <= sidx_next;
                if (emit)
                    res_reg <= res_next;
            end
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.result_kind    = res_reg.result_kind;
    assign results.reliability    = res_reg.reliability;
    assign results.split_flag     = res_reg.split_flag;
    assign results.payload_length = res_reg.payload_length;
    assign results.message_index  = res_reg.message_index;
    assign results.order_index    = res_reg.order_index;
    assign results.order_channel  = res_reg.order_channel;
    assign results.split_count    = res_reg.split_count;
    assign results.split_id       = res_reg.split_id;
    assign results.split_index    = res_reg.split_index;
    assign results.payload_byte   = res_reg.payload_byte;
    assign results.frame_end      = res_reg.frame_end;
endmodule

// ===== hdl/encapsulated_frame_parser_core.sv =====
// Path: a word that yields a result passes the input register, then the
//   parse logic into the result register.
// Throughput: one input word per cycle while the result side keeps up; the
//   parse state advances once per word, the result register on each result.
// Reset: rst_n is asynchronous, active low; clears both stages and returns
//   the parser to expecting a flags byte.
module encapsulated_frame_parser_core (
    input  logic         clk,
    input  logic         rst_n,
    efp_byte_if.sink     bytes,
    efp_result_if.source results
);
    import efp_pkg::*;

    logic  word_valid;
    word_t word;
    logic  take;

    efp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .take       (take),
        .word_valid (word_valid),
        .word       (word)
    );

    efp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word       (word),
        .take       (take),
        .results    (results)
    );
endmodule

// ===== hdl/efp_checker.sv =====
module efp_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             valid,
    input logic                             ready,
    input logic [1:0]                       result_kind,
    input logic [efp_pkg::RELIABILITY_W-1:0] reliability,
    input logic                             split_flag,
    input logic [efp_pkg::PAYLOAD_LEN_W-1:0] payload_length,
    input logic [efp_pkg::INDEX24_W-1:0]    message_index,
    input logic [efp_pkg::SPLIT_CNT_W-1:0]  split_count,
    input logic [efp_pkg::BYTE_W-1:0]       payload_byte,
    input logic                             frame_end
);
    import efp_pkg::*;

    // stalled word holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(result_kind) && $stable(payload_byte)
                            && $stable(frame_end))
        else $error("result word changed while stalled");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> result_kind == KIND_HEADER || result_kind == KIND_PAYLOAD
                  || result_kind == KIND_TRUNC)
        else $error("illegal result kind");

    a_header_len: assert property (@(posedge clk) disable iff (!rst_n)
        valid && result_kind == KIND_HEADER
            |-> payload_length <= MAX_PAYLOAD_LEN && frame_end == (payload_length == '0))
        else $error("header length or frame end inconsistent");

    a_non_header_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && result_kind != KIND_HEADER
            |-> reliability == '0 && !split_flag && payload_length == '0
                && message_index == '0 && split_count == '0)
        else $error("header fields set on a non-header word");

    a_trunc_clean: assert property (@(posedge clk) disable iff (!rst_n)
        valid && result_kind == KIND_TRUNC |-> payload_byte == '0 && !frame_end)
        else $error("error word carries payload fields");
endmodule

bind encapsulated_frame_parser_core efp_checker u_efp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid          (results.valid),
    .ready          (results.ready),
    .result_kind    (results.result_kind),
    .reliability    (results.reliability),
    .split_flag     (results.split_flag),
    .payload_length (results.payload_length),
    .message_index  (results.message_index),
    .split_count    (results.split_count),
    .payload_byte   (results.payload_byte),
    .frame_end      (results.frame_end)
);

// ===== dv/tb_encapsulated_frame_parser_core.sv =====
module tb_encapsulated_frame_parser_core;
    import efp_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int RANDOM_WORDS = 600;
    localparam int REPORT_LINES = 40;
    localparam int BIG_BURST    = 24;

    typedef enum logic [2:0] {
        REL_UNRELIABLE       = 3'd0,
        REL_UNRELIABLE_SEQ   = 3'd1,
        REL_RELIABLE         = 3'd2,
        REL_RELIABLE_ORD     = 3'd3,
        REL_RELIABLE_SEQ     = 3'd4,
        REL_UNRELIABLE_ACK   = 3'd5,
        REL_RELIABLE_ACK     = 3'd6,
        REL_RELIABLE_ORD_ACK = 3'd7
    } reliability_e;

    typedef enum logic [3:0] {
        P_FLAGS,
        P_LEN_HI,
        P_LEN_LO,
        P_MSG_IDX,
        P_ORD_IDX,
        P_ORD_CHAN,
        P_SPLIT_CNT,
        P_SPLIT_ID,
        P_SPLIT_IDX,
        P_DONE,
        P_PAYLOAD
    } parse_phase_e;

    function automatic bit carries_msg_index(logic [2:0] r);
        return r == REL_RELIABLE || r == REL_RELIABLE_ORD || r == REL_RELIABLE_SEQ ||
               r == REL_RELIABLE_ACK || r == REL_RELIABLE_ORD_ACK;
    endfunction

    function automatic bit carries_order(logic [2:0] r);
        return r == REL_UNRELIABLE_SEQ || r == REL_RELIABLE_ORD || r == REL_RELIABLE_SEQ ||
               r == REL_RELIABLE_ORD_ACK;
    endfunction

    class frame_scoreboard;
        parse_phase_e phase;
        logic [2:0]   field_cnt;
        logic [2:0]   rel;
        logic         split;
        logic [15:0]  bit_len;
        logic [13:0]  remaining;
        logic [23:0]  msg_idx;
        logic [23:0]  ord_idx;
        logic [7:0]   ord_chan;
        logic [31:0]  split_cnt;
        logic [15:0]  split_id;
        logic [31:0]  split_idx;
        result_t      expected_records[$];
        int           mismatches;
        int           words_checked;
        int           kind_count[3];

        function new();
            phase     = P_FLAGS;
            field_cnt = '0;
            rel       = '0;
            split     = 1'b0;
            remaining = '0;
            clear_fields();
            mismatches    = 0;
            words_checked = 0;
            kind_count    = '{0, 0, 0};
        endfunction

        function void clear_fields();
            bit_len   = '0;
            msg_idx   = '0;
            ord_idx   = '0;
            ord_chan  = '0;
            split_cnt = '0;
            split_id  = '0;
            split_idx = '0;
        endfunction

        function bit field_present(parse_phase_e ph);
            case (ph)
                P_MSG_IDX:                            return carries_msg_index(rel);
                P_ORD_IDX, P_ORD_CHAN:                return carries_order(rel);
                P_SPLIT_CNT, P_SPLIT_ID, P_SPLIT_IDX: return split;
                default:                              return 1'b1;
            endcase
        endfunction

        function parse_phase_e phase_after(parse_phase_e ph);
            parse_phase_e n;
            n = parse_phase_e'(ph + 1);
            while (n < P_DONE && !field_present(n))
                n = parse_phase_e'(n + 1);
            return n;
        endfunction

        function void advance_field(logic [2:0] last_cnt);
            if (field_cnt == last_cnt)
            begin
                field_cnt = '0;
                phase     = phase_after(phase);
            end
            else
                field_cnt = field_cnt + 1'b1;
        endfunction

        // Updates the parse state for one accepted byte and queues any word it causes.
        function void note_byte(logic [7:0] b, logic eod);
            result_t     rec;
            bit          emit;
            logic [16:0] len;
            rec  = '0;
            emit = 1'b0;
            case (phase)
                P_LEN_HI:
                begin
                    bit_len[15:8] = b;
                    phase = P_LEN_LO;
                end
                P_LEN_LO:
                begin
                    bit_len[7:0] = b;
                    phase = phase_after(P_LEN_LO);
                end
                P_MSG_IDX:
                begin
                    msg_idx[8*field_cnt +: 8] = b;
                    advance_field(3'd2);
                end
                P_ORD_IDX:
                begin
                    ord_idx[8*field_cnt +: 8] = b;
                    advance_field(3'd2);
                end
                P_ORD_CHAN:
                begin
                    ord_chan = b;
                    phase = phase_after(P_ORD_CHAN);
                end
                P_SPLIT_CNT:
                begin
                    split_cnt = {split_cnt[23:0], b};
                    advance_field(3'd3);
                end
                P_SPLIT_ID:
                begin
                    split_id = {split_id[7:0], b};
                    advance_field(3'd1);
                end
                P_SPLIT_IDX:
                begin
                    split_idx = {split_idx[23:0], b};
                    advance_field(3'd3);
                end
                P_PAYLOAD:
                begin
                    rec.result_kind  = KIND_PAYLOAD;
                    rec.payload_byte = b;
                    remaining = remaining - 1'b1;
                    if (remaining == 0)
                    begin
                        rec.frame_end = 1'b1;
                        phase = P_FLAGS;
                    end
                    emit = 1'b1;
                end
                default:
                begin
                    // low nibble of the flags byte is don't-care
                    rel       = b[7:5];
                    split     = b[4];
                    clear_fields();
                    field_cnt = '0;
                    phase     = P_LEN_HI;
                end
            endcase

            if (phase == P_DONE)
            begin
                len = ({1'b0, bit_len} + 17'd7) >> 3;
                remaining          = len[13:0];
                rec.result_kind    = KIND_HEADER;
                rec.reliability    = rel;
                rec.split_flag     = split;
                rec.payload_length = len[13:0];
                rec.message_index  = msg_idx;
                rec.order_index    = ord_idx;
                rec.order_channel  = ord_chan;
                rec.split_count    = split_cnt;
                rec.split_id       = split_id;
                rec.split_index    = split_idx;
                rec.frame_end      = (len == 0);
                phase = (len == 0) ? P_FLAGS : P_PAYLOAD;
                emit  = 1'b1;
            end

            // datagram ended inside a frame: error word replaces anything else
            if (eod && phase != P_FLAGS)
            begin
                rec = '0;
                rec.result_kind = KIND_TRUNC;
                phase     = P_FLAGS;
                field_cnt = '0;
                remaining = '0;
                emit      = 1'b1;
            end

            if (emit)
                expected_records.insert(expected_records.size(), rec);
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= REPORT_LINES)
                $display("ERROR: %s", msg);
        endtask

        task compare_field(string name, logic [31:0] got_v, logic [31:0] want_v);
            if (got_v !== want_v)
                report($sformatf("word %0d: %s is 0x%0h, expected 0x%0h",
                                 words_checked, name, got_v, want_v));
        endtask

        task check_result(result_t got);
            result_t want;
            if (expected_records.size() == 0)
            begin
                report($sformatf("word %0d arrived with nothing expected", words_checked));
                words_checked++;
                return;
            end
            want = expected_records.pop_front();
            compare_field("result_kind", 32'(got.result_kind), 32'(want.result_kind));
            compare_field("reliability", 32'(got.reliability), 32'(want.reliability));
            compare_field("split_flag", 32'(got.split_flag), 32'(want.split_flag));
            compare_field("payload_length", 32'(got.payload_length),
                          32'(want.payload_length));
            compare_field("message_index", 32'(got.message_index),
                          32'(want.message_index));
            compare_field("order_index", 32'(got.order_index), 32'(want.order_index));
            compare_field("order_channel", 32'(got.order_channel),
                          32'(want.order_channel));
            compare_field("split_count", got.split_count, want.split_count);
            compare_field("split_id", 32'(got.split_id), 32'(want.split_id));
            compare_field("split_index", got.split_index, want.split_index);
            compare_field("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
            compare_field("frame_end", 32'(got.frame_end), 32'(want.frame_end));
            kind_count[want.result_kind]++;
            words_checked++;
        endtask
    endclass

    logic clk;
    logic rst_n;

    efp_byte_if   byte_ch();
    efp_result_if result_ch();

    encapsulated_frame_parser_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (byte_ch),
        .results (result_ch)
    );

    frame_scoreboard sb = new();
    logic [7:0]      datagram_bytes[$];
    bit              steady_flow;
    int              words_sent;
    int              datagrams_sent;
    int              datagrams_cut;
    int              noise_datagrams;
    int              cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Mostly short gaps, a few long ones; none while steady_flow is set.
    function automatic int pick_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] random_bit_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 16'd0;
        if (r < 70)
            return 16'($urandom_range(1, 64));
        if (r < 95)
            return 16'($urandom_range(65, 400));
        return 16'($urandom_range(401, 2048));
    endfunction

    function automatic void append_byte(input logic [7:0] b);
        datagram_bytes.insert(datagram_bytes.size(), b);
    endfunction

    task automatic append_frame(input logic [2:0] rel, input logic split,
                                input logic [3:0] nibble, input logic [15:0] bits,
                                input logic [23:0] msg, input logic [23:0] ord,
                                input logic [7:0] chan, input logic [31:0] scnt,
                                input logic [15:0] sid, input logic [31:0] sidx);
        int nbytes;
        nbytes = (int'(bits) + 7) >> 3;
        append_byte({rel, split, nibble});
        append_byte(bits[15:8]);
        append_byte(bits[7:0]);
        if (carries_msg_index(rel))
            for (int i = 0; i < 3; i++)
                append_byte(msg[8*i +: 8]);
        if (carries_order(rel))
        begin
            for (int i = 0; i < 3; i++)
                append_byte(ord[8*i +: 8]);
            append_byte(chan);
        end
        if (split)
        begin
            for (int i = 3; i >= 0; i--)
                append_byte(scnt[8*i +: 8]);
            append_byte(sid[15:8]);
            append_byte(sid[7:0]);
            for (int i = 3; i >= 0; i--)
                append_byte(sidx[8*i +: 8]);
        end
        repeat (nbytes)
            append_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic append_random_frame(input logic [15:0] bits);
        append_frame(3'($urandom_range(0, 7)), $urandom_range(0, 2) == 0,
                     4'($urandom_range(0, 15)), bits, 24'($urandom), 24'($urandom),
                     8'($urandom), $urandom, 16'($urandom), $urandom);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input logic [7:0] b, input logic eod);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_ch.valid           <= 1'b1;
        byte_ch.data_byte       <= b;
        byte_ch.end_of_datagram <= eod;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        sb.note_byte(b, eod);
        words_sent++;
        @(negedge clk);
    endtask

    // keep = 0 or keep >= size sends the whole datagram; otherwise it ends after keep bytes.
    task automatic send_datagram(input int keep);
        int n;
        n = (keep > 0 && keep < datagram_bytes.size()) ? keep : datagram_bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(datagram_bytes[i], i == n - 1);
        datagram_bytes.delete();
        datagrams_sent++;
    endtask

    task automatic hold_until_drained();
        byte_ch.valid <= 1'b0;
        while (sb.expected_records.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin : result_ready_driver
        int stall_left;
        stall_left      = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_monitor
        result_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.result_kind    = kind_t'(result_ch.result_kind);
            got.reliability    = result_ch.reliability;
            got.split_flag     = result_ch.split_flag;
            got.payload_length = result_ch.payload_length;
            got.message_index  = result_ch.message_index;
            got.order_index    = result_ch.order_index;
            got.order_channel  = result_ch.order_channel;
            got.split_count    = result_ch.split_count;
            got.split_id       = result_ch.split_id;
            got.split_index    = result_ch.split_index;
            got.payload_byte   = result_ch.payload_byte;
            got.frame_end      = result_ch.frame_end;
            sb.check_result(got);
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("encapsulated_frame_parser_core test failed");
        $finish;
    end

    initial
    begin : stimulus
        int  kind;
        int  keep;
        int  random_start;
        int  drain_wait;
        bit  big_frame_done;
        rst_n                   = 1'b0;
        steady_flow             = 1'b0;
        big_frame_done          = 1'b0;
        byte_ch.valid           = 1'b0;
        byte_ch.data_byte       = '0;
        byte_ch.end_of_datagram = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty frame, flags low nibble all ones
        append_frame(REL_UNRELIABLE, 1'b0, 4'hF, 16'd0, '0, '0, '0, '0, '0, '0);
        send_datagram(0);
        // every optional field present and all ones, one payload byte
        append_frame(REL_RELIABLE_ORD_ACK, 1'b1, 4'hF, 16'd1, '1, '1, '1, '1, '1, '1);
        send_datagram(0);
        // datagram ends right on a flags byte
        append_random_frame(16'd8);
        send_datagram(1);
        hold_until_drained();

        random_start = words_sent;
        while (words_sent - random_start < RANDOM_WORDS)
        begin
            steady_flow = ($urandom_range(0, 7) == 0);
            kind = $urandom_range(0, 99);
            if (!big_frame_done && words_sent - random_start > RANDOM_WORDS / 2)
            begin
                // header of the longest frame, then a short back-to-back burst before the cut
                big_frame_done = 1'b1;
                steady_flow    = 1'b1;
                append_random_frame(16'hFFFF);
                send_datagram(datagram_bytes.size() - int'(MAX_PAYLOAD_LEN) + BIG_BURST);
                datagrams_cut++;
            end
            else if (kind < 15)
            begin
                repeat ($urandom_range(1, 12))
                    append_byte(8'($urandom_range(0, 255)));
                send_datagram(0);
                noise_datagrams++;
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                    append_random_frame(random_bit_length());
                keep = 0;
                if (kind < 35)
                begin
                    keep = $urandom_range(1, datagram_bytes.size() - 1);
                    datagrams_cut++;
                end
                send_datagram(keep);
            end
            if (datagrams_sent % 40 == 0)
                hold_until_drained();
        end

        byte_ch.valid <= 1'b0;
        steady_flow = 1'b0;
        drain_wait  = 0;
        while (sb.expected_records.size() != 0 && drain_wait < 100000)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (8) @(posedge clk);
        if (sb.expected_records.size() != 0)
            sb.report($sformatf("%0d expected words never arrived",
                                sb.expected_records.size()));

        $display("Sent %0d datagrams in %0d input words: %0d cut short, %0d random noise.",
                 datagrams_sent, words_sent, datagrams_cut, noise_datagrams);
        $display("Checked %0d output words: %0d headers, %0d payload bytes, %0d truncations.",
                 sb.words_checked, sb.kind_count[KIND_HEADER], sb.kind_count[KIND_PAYLOAD],
                 sb.kind_count[KIND_TRUNC]);
        if (sb.mismatches == 0)
            $display("encapsulated_frame_parser_core test passed");
        else
            $display("encapsulated_frame_parser_core test failed");
        $finish;
    end

endmodule
